// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the LCD sequencer controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

// ===== rtl/core/clcd_pkg.sv =====
// Types, constants and the start-up table of the character LCD sequencer
package clcd_pkg;

  localparam int unsigned LINE_COLUMNS_DEF = 40;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_GOTO  = 2'd2,
    OP_PUT   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_PULSE = 2'd0,
    ACT_BUSY  = 2'd1,
    ACT_DELAY = 2'd2
  } act_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_CLR,
    ST_PUT,
    ST_GOTO_A,
    ST_GOTO_B
  } st_e;

  typedef enum logic [3:0] {
    SRC_TABLE,
    SRC_WAIT,
    SRC_CLR_HI,
    SRC_CLR_LO,
    SRC_CLR_DLY,
    SRC_CHAR_HI,
    SRC_CHAR_LO,
    SRC_TGTA_HI,
    SRC_TGTA_LO,
    SRC_TGTB_HI,
    SRC_TGTB_LO
  } src_e;

  typedef struct packed {
    act_e       action;
    logic       rs;
    logic [3:0] nibble;
    logic [6:0] delay_ms;
  } act_t;

  // controller to datapath
  typedef struct packed {
    logic       accept;
    logic       emit;
    src_e       src;
    logic [5:0] idx;
    logic       last;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic plan_a;
    logic plan_b;
  } stat_t;

  localparam logic [5:0] INIT_LAST = 6'd50;
  localparam logic [5:0] CLR_LAST  = 6'd3;
  localparam logic [5:0] SEQ_LAST  = 6'd2;

  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0F;
  localparam logic [7:0] CMD_DISP_NCUR = 8'h0C;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [6:0] ROW1_OFFSET   = 7'h40;
  localparam logic [6:0] CLEAR_DLY_MS  = 7'd3;
  localparam logic [2:0] ROWS_WRAP     = 3'd2;
  localparam logic [2:0] ROWS_RESET    = 3'd2;

  function automatic act_t pulse_act(logic rs, logic [3:0] nib);
    act_t a;
    a.action   = ACT_PULSE;
    a.rs       = rs;
    a.nibble   = nib;
    a.delay_ms = 7'd0;
    return a;
  endfunction

  function automatic act_t busy_act();
    act_t a;
    a.action   = ACT_BUSY;
    a.rs       = 1'b0;
    a.nibble   = 4'd0;
    a.delay_ms = 7'd0;
    return a;
  endfunction

  function automatic act_t delay_act(logic [6:0] ms);
    act_t a;
    a.action   = ACT_DELAY;
    a.rs       = 1'b0;
    a.nibble   = 4'd0;
    a.delay_ms = ms;
    return a;
  endfunction

  // start-up run is played twice, then the final display-on command
  function automatic act_t init_action(logic [5:0] idx);
    logic [5:0] k;
    act_t       a;
    k = (idx >= 6'd24) ? idx - 6'd24 : idx;
    a = busy_act();
    if (idx >= 6'd48) begin
      case (idx)
        6'd48:   a = busy_act();
        6'd49:   a = pulse_act(1'b0, CMD_DISP_NCUR[7:4]);
        6'd50:   a = pulse_act(1'b0, CMD_DISP_NCUR[3:0]);
        default: a = busy_act();
      endcase
    end else begin
      case (k)
        6'd0:    a = delay_act(7'd100);
        6'd1:    a = pulse_act(1'b0, 4'h3);
        6'd2:    a = delay_act(7'd5);
        6'd3:    a = pulse_act(1'b0, 4'h3);
        6'd4:    a = delay_act(7'd1);
        6'd5:    a = pulse_act(1'b0, 4'h3);
        6'd6:    a = delay_act(7'd1);
        6'd7:    a = pulse_act(1'b0, 4'h2);
        6'd8:    a = delay_act(7'd4);
        6'd9:    a = pulse_act(1'b0, CMD_FUNC_SET[7:4]);
        6'd10:   a = pulse_act(1'b0, CMD_FUNC_SET[3:0]);
        6'd11:   a = busy_act();
        6'd12:   a = pulse_act(1'b0, CMD_DISP_OFF[7:4]);
        6'd13:   a = pulse_act(1'b0, CMD_DISP_OFF[3:0]);
        6'd14:   a = busy_act();
        6'd15:   a = pulse_act(1'b0, CMD_CLEAR[7:4]);
        6'd16:   a = pulse_act(1'b0, CMD_CLEAR[3:0]);
        6'd17:   a = delay_act(CLEAR_DLY_MS);
        6'd18:   a = busy_act();
        6'd19:   a = pulse_act(1'b0, CMD_ENTRY[7:4]);
        6'd20:   a = pulse_act(1'b0, CMD_ENTRY[3:0]);
        6'd21:   a = busy_act();
        6'd22:   a = pulse_act(1'b0, CMD_DISP_ON[7:4]);
        6'd23:   a = pulse_act(1'b0, CMD_DISP_ON[3:0]);
        default: a = busy_act();
      endcase
    end
    return a;
  endfunction

endpackage

// ===== rtl/core/clcd_ifs.sv =====
// Request channel interfaces of the LCD sequencer: command, action, config
interface clcd_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] char_code;
  logic [5:0] column;
  logic [1:0] row;
  modport source (output valid, operation, char_code, column, row, input ready);
  modport sink   (input valid, operation, char_code, column, row, output ready);
endinterface

interface clcd_act_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       register_select;
  logic [3:0] nibble;
  logic [6:0] delay_ms;
  logic       last;
  modport source (output valid, action, register_select, nibble, delay_ms, last,
                  input ready);
  modport sink   (input valid, action, register_select, nibble, delay_ms, last,
                  output ready);
endinterface

interface clcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] row_count;
  modport source (output valid, row_count, input ready);
  modport sink   (input valid, row_count, output ready);
endinterface

// ===== rtl/core/clcd_dp.sv =====
// Datapath: cursor, latched command, put-character plan and action register
module clcd_dp
  import clcd_pkg::*;
#(
  parameter int unsigned LINE_COLUMNS = LINE_COLUMNS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctl_t       ctl_i,
  output stat_t      stat_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] char_code_i,
  input  logic [5:0] column_i,
  input  logic [1:0] row_i,
  input  logic       cfg_valid_i,
  input  logic [2:0] cfg_row_count_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output act_t       out_act_o,
  output logic       out_last_o
);

  localparam logic [6:0] LineCols = 7'(LINE_COLUMNS);

  logic [2:0] row_count_q;
  logic [5:0] cur_col_q, cur_col_d;
  logic [1:0] cur_row_q, cur_row_d;
  logic [7:0] char_q;
  logic [5:0] tgta_col_q, tgta_col_d;
  logic [1:0] tgta_row_q, tgta_row_d;
  logic [5:0] tgtb_col_q, tgtb_col_d;
  logic       plan_a_q, plan_a_d, plan_b_q, plan_b_d;
  logic       out_valid_q, out_valid_d;
  act_t       out_act_q, out_act_d;
  logic       out_last_q, out_last_d;

  logic [6:0] col1, col_a, col_b;
  logic [2:0] row_inc;
  logic [1:0] row_a;
  logic       wrap_a, wrap_b;
  logic [7:0] addr_a, addr_b;

  // put character: line wrap and row 1 re-address
  always_comb begin
    col1    = {1'b0, cur_col_q} + 7'd1;
    wrap_a  = (row_count_q == ROWS_WRAP) && (col1 >= LineCols);
    row_inc = {1'b0, cur_row_q} + 3'd1;
    if (wrap_a) begin
      row_a = (row_inc >= 3'd2) ? 2'd0 : row_inc[1:0];
      col_a = 7'd0;
    end else begin
      row_a = cur_row_q;
      col_a = col1;
    end
    wrap_b = (row_a == 2'd1);
    col_b  = (wrap_b && (col_a >= LineCols)) ? 7'd0 : col_a;
  end

  always_comb begin
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    tgta_col_d = tgta_col_q;
    tgta_row_d = tgta_row_q;
    tgtb_col_d = tgtb_col_q;
    plan_a_d   = plan_a_q;
    plan_b_d   = plan_b_q;
    if (ctl_i.accept) begin
      plan_a_d   = 1'b0;
      plan_b_d   = 1'b0;
      tgta_col_d = 6'd0;
      tgta_row_d = 2'd0;
      case (op_e'(operation_i))
        OP_INIT, OP_CLEAR: begin
          cur_col_d = 6'd0;
          cur_row_d = 2'd0;
        end
        OP_GOTO: begin
          tgta_col_d = column_i;
          tgta_row_d = row_i;
          cur_col_d  = column_i;
          cur_row_d  = row_i;
        end
        OP_PUT: begin
          plan_a_d   = wrap_a;
          plan_b_d   = wrap_b;
          tgta_row_d = row_a;
          tgtb_col_d = col_b[5:0];
          cur_col_d  = col_b[5:0];
          cur_row_d  = row_a;
        end
        default: ;
      endcase
    end
  end

  assign addr_a = CMD_SET_DDRAM | {1'b0, {1'b0, tgta_col_q} +
                  ((tgta_row_q != 2'd0) ? ROW1_OFFSET : 7'd0)};
  assign addr_b = CMD_SET_DDRAM | {1'b0, {1'b0, tgtb_col_q} + ROW1_OFFSET};

  always_comb begin
    out_valid_d = out_valid_q;
    out_act_d   = out_act_q;
    out_last_d  = out_last_q;
    if (ctl_i.emit) begin
      out_valid_d = 1'b1;
      out_last_d  = ctl_i.last;
      case (ctl_i.src)
        SRC_TABLE:   out_act_d = init_action(ctl_i.idx);
        SRC_WAIT:    out_act_d = busy_act();
        SRC_CLR_HI:  out_act_d = pulse_act(1'b0, CMD_CLEAR[7:4]);
        SRC_CLR_LO:  out_act_d = pulse_act(1'b0, CMD_CLEAR[3:0]);
        SRC_CLR_DLY: out_act_d = delay_act(CLEAR_DLY_MS);
        SRC_CHAR_HI: out_act_d = pulse_act(1'b1, char_q[7:4]);
        SRC_CHAR_LO: out_act_d = pulse_act(1'b1, char_q[3:0]);
        SRC_TGTA_HI: out_act_d = pulse_act(1'b0, addr_a[7:4]);
        SRC_TGTA_LO: out_act_d = pulse_act(1'b0, addr_a[3:0]);
        SRC_TGTB_HI: out_act_d = pulse_act(1'b0, addr_b[7:4]);
        SRC_TGTB_LO: out_act_d = pulse_act(1'b0, addr_b[3:0]);
        default:     out_act_d = busy_act();
      endcase
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROWS_RESET;
      cur_col_q   <= 6'd0;
      cur_row_q   <= 2'd0;
      plan_a_q    <= 1'b0;
      plan_b_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        row_count_q <= cfg_row_count_i;
      end
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      plan_a_q    <= plan_a_d;
      plan_b_q    <= plan_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      char_q <= char_code_i;
    end
    tgta_col_q <= tgta_col_d;
    tgta_row_q <= tgta_row_d;
    tgtb_col_q <= tgtb_col_d;
    out_act_q  <= out_act_d;
    out_last_q <= out_last_d;
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.plan_a   = plan_a_q;
  assign stat_o.plan_b   = plan_b_q;
  assign out_valid_o     = out_valid_q;
  assign out_act_o       = out_act_q;
  assign out_last_o      = out_last_q;

endmodule

// ===== rtl/core/clcd_ctrl.sv =====
// Controller: command sequencing state machine of the LCD sequencer
`include "assert_macros.svh"

module clcd_ctrl
  import clcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] operation_i,
  output logic       in_ready_o,
  input  stat_t      stat_i,
  output ctl_t       ctl_o
);

  st_e        state_q, state_d;
  logic [5:0] step_q, step_d;
  logic       seg_end;

  always_comb begin
    case (state_q)
      ST_INIT:               seg_end = (step_q == INIT_LAST);
      ST_CLR:                seg_end = (step_q == CLR_LAST);
      ST_PUT, ST_GOTO_A,
      ST_GOTO_B:             seg_end = (step_q == SEQ_LAST);
      default:               seg_end = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        step_d = 6'd0;
        if (in_valid_i) begin
          case (op_e'(operation_i))
            OP_INIT:  state_d = ST_INIT;
            OP_CLEAR: state_d = ST_CLR;
            OP_GOTO:  state_d = ST_GOTO_A;
            OP_PUT:   state_d = ST_PUT;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_INIT, ST_CLR, ST_PUT, ST_GOTO_A, ST_GOTO_B: begin
        if (stat_i.out_free) begin
          step_d = step_q + 6'd1;
          if (seg_end) begin
            step_d = 6'd0;
            case (state_q)
              ST_CLR:    state_d = ST_GOTO_A;
              ST_PUT:    state_d = stat_i.plan_a ? ST_GOTO_A :
                                   stat_i.plan_b ? ST_GOTO_B : ST_IDLE;
              ST_GOTO_A: state_d = stat_i.plan_b ? ST_GOTO_B : ST_IDLE;
              default:   state_d = ST_IDLE;
            endcase
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o.accept = (state_q == ST_IDLE) && in_valid_i;
    ctl_o.emit   = (state_q != ST_IDLE) && stat_i.out_free;
    ctl_o.idx    = step_q;
    ctl_o.src    = SRC_WAIT;
    ctl_o.last   = 1'b0;
    case (state_q)
      ST_INIT: begin
        ctl_o.src  = SRC_TABLE;
        ctl_o.last = seg_end;
      end
      ST_CLR: begin
        case (step_q)
          6'd1:    ctl_o.src = SRC_CLR_HI;
          6'd2:    ctl_o.src = SRC_CLR_LO;
          6'd3:    ctl_o.src = SRC_CLR_DLY;
          default: ctl_o.src = SRC_WAIT;
        endcase
      end
      ST_PUT: begin
        case (step_q)
          6'd1:    ctl_o.src = SRC_CHAR_HI;
          6'd2:    ctl_o.src = SRC_CHAR_LO;
          default: ctl_o.src = SRC_WAIT;
        endcase
        ctl_o.last = seg_end && !stat_i.plan_a && !stat_i.plan_b;
      end
      ST_GOTO_A: begin
        case (step_q)
          6'd1:    ctl_o.src = SRC_TGTA_HI;
          6'd2:    ctl_o.src = SRC_TGTA_LO;
          default: ctl_o.src = SRC_WAIT;
        endcase
        ctl_o.last = seg_end && !stat_i.plan_b;
      end
      ST_GOTO_B: begin
        case (step_q)
          6'd1:    ctl_o.src = SRC_TGTB_HI;
          6'd2:    ctl_o.src = SRC_TGTB_LO;
          default: ctl_o.src = SRC_WAIT;
        endcase
        ctl_o.last = seg_end;
      end
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= 6'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  `ASSERT_NEVER(a_idle_no_emit, (state_q == ST_IDLE) && ctl_o.emit, "emit while idle")
  `ASSERT_CLK(a_emit_free, ctl_o.emit |-> stat_i.out_free, "emit into full register")
  `ASSERT_CLK(a_init_step, (state_q == ST_INIT) |-> (step_q <= INIT_LAST), "init overrun")
  `ASSERT_CLK(a_last_idle, (ctl_o.emit && ctl_o.last) |=> (state_q == ST_IDLE),
              "last action without return to idle")

endmodule

// ===== rtl/core/char_lcd_4bit_command_sequencer.sv =====
// Top level of the 4-bit character LCD command sequencer
//
// cmd_i takes one command per request: init, clear, goto column/row or put
// character. act_o gives the resulting bus actions in order: a nibble pulse
// with register select, a wait-until-not-busy, or a delay in milliseconds;
// last marks the final action of a command. cfg_i writes row_count and is
// always ready; write it only while no command is in progress.
// Commands are handled one at a time. cmd_i is ready while the controller is
// idle; after acceptance the controller emits one action per cycle into the
// output register while act_o does not stall. The first action reaches act_o
// through the controller state register and then the output register. The
// rate is set by the single output register, filled by the controller one
// action per cycle whenever the register is free.
// When act_o stalls, the controller holds its step until the register drains.
// A new command can be accepted while the last action still waits in the
// output register.
// Reset puts the cursor at column 0, row 0, row_count at 2 and empties the
// output register; no start-up sequence is sent until an init command.
module char_lcd_4bit_command_sequencer
  import clcd_pkg::*;
#(
  parameter int unsigned LINE_COLUMNS = LINE_COLUMNS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  clcd_cmd_if.sink       cmd_i,
  clcd_act_if.source     act_o,
  clcd_cfg_if.sink       cfg_i
);

  ctl_t  ctl;
  stat_t stat;
  act_t  out_act;
  logic  in_ready;
  logic  out_valid;
  logic  out_last;

  clcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .operation_i (cmd_i.operation),
    .in_ready_o  (in_ready),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  clcd_dp #(
    .LINE_COLUMNS (LINE_COLUMNS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .stat_o          (stat),
    .operation_i     (cmd_i.operation),
    .char_code_i     (cmd_i.char_code),
    .column_i        (cmd_i.column),
    .row_i           (cmd_i.row),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_row_count_i (cfg_i.row_count),
    .out_ready_i     (act_o.ready),
    .out_valid_o     (out_valid),
    .out_act_o       (out_act),
    .out_last_o      (out_last)
  );

  assign cmd_i.ready           = in_ready;
  assign cfg_i.ready           = 1'b1;
  assign act_o.valid           = out_valid;
  assign act_o.action          = out_act.action;
  assign act_o.register_select = out_act.rs;
  assign act_o.nibble          = out_act.nibble;
  assign act_o.delay_ms        = out_act.delay_ms;
  assign act_o.last            = out_last;

endmodule

// ===== tb/sv/char_lcd_4bit_command_sequencer_tb.sv =====
// Self-checking testbench for the 4-bit character LCD command sequencer
module char_lcd_4bit_command_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clcd_pkg::*;

  localparam int unsigned LINE_COLS   = LINE_COLUMNS_DEF;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned ITEMS_PER_PHASE = 36;

  typedef struct {
    act_e       action;
    logic       rs;
    logic [3:0] nibble;
    logic [6:0] delay_ms;
    logic       last;
  } bus_action_t;

  logic clk;
  logic rst_n;

  clcd_cmd_if cmd_if ();
  clcd_act_if act_if ();
  clcd_cfg_if cfg_if ();

  char_lcd_4bit_command_sequencer #(
    .LINE_COLUMNS(LINE_COLS)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_if),
    .act_o (act_if),
    .cfg_i (cfg_if)
  );

  bus_action_t expected_actions[$];
  logic [5:0]  cursor_col;
  logic [1:0]  cursor_row;
  logic [2:0]  row_count_cfg;

  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned hold_off_left;
  int unsigned stall_left;
  bit          idle_on;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("char_lcd_4bit_command_sequencer test failed");
      $finish;
    end
  end

  // --- expected bus actions ---

  function automatic void queue_action(act_e a, logic rs, logic [3:0] nib, logic [6:0] ms);
    bus_action_t e;
    e.action   = a;
    e.rs       = rs;
    e.nibble   = nib;
    e.delay_ms = ms;
    e.last     = 1'b0;
    expected_actions.push_back(e);
  endfunction

  function automatic void queue_byte(logic rs, logic [7:0] b);
    queue_action(ACT_PULSE, rs, b[7:4], 7'd0);
    queue_action(ACT_PULSE, rs, b[3:0], 7'd0);
  endfunction

  function automatic void queue_busy();
    queue_action(ACT_BUSY, 1'b0, 4'd0, 7'd0);
  endfunction

  function automatic void queue_delay(logic [6:0] ms);
    queue_action(ACT_DELAY, 1'b0, 4'd0, ms);
  endfunction

  function automatic void queue_goto(logic [5:0] col, logic [1:0] row);
    logic [7:0] addr;
    addr = {2'b00, col} + ((row != 2'd0) ? 8'h40 : 8'h00);
    queue_busy();
    queue_byte(1'b0, 8'h80 | addr);
    cursor_col = col;
    cursor_row = row;
  endfunction

  function automatic void queue_startup();
    for (int i = 0; i < 2; i++) begin
      queue_delay(7'd100);
      queue_action(ACT_PULSE, 1'b0, 4'h3, 7'd0);
      queue_delay(7'd5);
      queue_action(ACT_PULSE, 1'b0, 4'h3, 7'd0);
      queue_delay(7'd1);
      queue_action(ACT_PULSE, 1'b0, 4'h3, 7'd0);
      queue_delay(7'd1);
      queue_action(ACT_PULSE, 1'b0, 4'h2, 7'd0);
      queue_delay(7'd4);
      queue_byte(1'b0, 8'h28);
      queue_busy();
      queue_byte(1'b0, 8'h08);
      queue_busy();
      queue_byte(1'b0, 8'h01);
      queue_delay(7'd3);
      queue_busy();
      queue_byte(1'b0, 8'h06);
      queue_busy();
      queue_byte(1'b0, 8'h0F);
    end
    queue_busy();
    queue_byte(1'b0, 8'h0C);
  endfunction

  function automatic void queue_put(logic [7:0] ch);
    logic [6:0] next_col;
    logic [2:0] next_row;
    queue_busy();
    queue_byte(1'b1, ch);
    next_col = {1'b0, cursor_col} + 7'd1;
    next_row = {1'b0, cursor_row};
    if (row_count_cfg == 3'd2 && next_col >= LINE_COLS) begin
      next_col = 7'd0;
      next_row = next_row + 3'd1;
      if (next_row >= 3'd2) next_row = 3'd0;
      queue_goto(next_col[5:0], next_row[1:0]);
    end
    if (next_row == 3'd1) begin
      if (next_col >= LINE_COLS) next_col = 7'd0;
      queue_goto(next_col[5:0], next_row[1:0]);
    end
    cursor_col = next_col[5:0];
    cursor_row = next_row[1:0];
  endfunction

  function automatic void predict_command(op_e op, logic [7:0] ch, logic [5:0] col,
                                          logic [1:0] row);
    case (op)
      OP_INIT: begin
        cursor_col = 6'd0;
        cursor_row = 2'd0;
        queue_startup();
      end
      OP_CLEAR: begin
        queue_busy();
        queue_byte(1'b0, 8'h01);
        queue_delay(7'd3);
        queue_goto(6'd0, 2'd0);
      end
      OP_GOTO: queue_goto(col, row);
      default: queue_put(ch);
    endcase
    expected_actions[expected_actions.size() - 1].last = 1'b1;
  endfunction

  // --- result checking ---

  always @(posedge clk) begin
    bus_action_t e;
    if (rst_n && act_if.valid === 1'b1 && act_if.ready === 1'b1) begin
      if (expected_actions.size() == 0) begin
        if (mismatch_count < 10)
          $display("cycle %0d: unexpected action %0d rs %0b nibble %h delay %0d last %0b",
                   cycle_count, act_if.action, act_if.register_select, act_if.nibble,
                   act_if.delay_ms, act_if.last);
        mismatch_count++;
      end else begin
        e = expected_actions.pop_front();
        if (act_if.action !== e.action || act_if.register_select !== e.rs ||
            act_if.nibble !== e.nibble || act_if.delay_ms !== e.delay_ms ||
            act_if.last !== e.last) begin
          if (mismatch_count < 10)
            $display("cycle %0d: expected %0d/%0b/%h/%0d/%0b got %0d/%0b/%h/%0d/%0b",
                     cycle_count, e.action, e.rs, e.nibble, e.delay_ms, e.last,
                     act_if.action, act_if.register_select, act_if.nibble,
                     act_if.delay_ms, act_if.last);
          mismatch_count++;
        end
      end
    end
  end

  // --- action sink: random stalls and the long hold-off ---

  initial begin
    act_if.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_off_left != 0) begin
      act_if.ready <= 1'b0;
      hold_off_left = hold_off_left - 1;
    end else if (stall_left != 0) begin
      act_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      act_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 9);
    end else begin
      act_if.ready <= 1'b1;
    end
  end

  // --- command source ---

  task automatic send_command(op_e op, logic [7:0] ch, logic [5:0] col, logic [1:0] row);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      cmd_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_if.valid     <= 1'b1;
    cmd_if.operation <= op;
    cmd_if.char_code <= ch;
    cmd_if.column    <= col;
    cmd_if.row       <= row;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
    predict_command(op, ch, col, row);
  endtask

  task automatic send_random_command();
    int unsigned pick;
    op_e         op;
    logic [7:0]  ch;
    logic [5:0]  col;
    logic [1:0]  row;
    pick = $urandom_range(0, 99);
    ch   = 8'($urandom_range(0, 255));
    row  = 2'($urandom_range(0, 3));
    col  = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(34, 39)) :
                                         6'($urandom_range(0, 63));
    if (pick < 5) op = OP_INIT;
    else if (pick < 14) op = OP_CLEAR;
    else if (pick < 36) op = OP_GOTO;
    else op = OP_PUT;
    send_command(op, ch, col, row);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (expected_actions.size() != 0) @(posedge clk);
  endtask

  task automatic write_row_count(logic [2:0] value);
    wait_drained();
    @(negedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.row_count <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    row_count_cfg = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // --- tests ---

  task automatic test_directed_commands();
    send_command(OP_PUT, 8'h00, 6'd0, 2'd0);
    send_command(OP_INIT, 8'hFF, 6'd63, 2'd3);
    send_command(OP_PUT, 8'hFF, 6'd0, 2'd0);
    send_command(OP_CLEAR, 8'h00, 6'd63, 2'd3);
    send_command(OP_GOTO, 8'h00, 6'd0, 2'd0);
    send_command(OP_GOTO, 8'hFF, 6'd63, 2'd3);
    send_command(OP_GOTO, 8'h5A, 6'd5, 2'd2);
    send_command(OP_PUT, 8'hA5, 6'd0, 2'd0);
  endtask

  // line end wrap with two rows, row 1 re-addressing, rows beyond 1
  task automatic test_line_wrap();
    send_command(OP_GOTO, 8'h00, 6'd38, 2'd0);
    send_command(OP_PUT, 8'h41, 6'd0, 2'd0);
    send_command(OP_PUT, 8'h42, 6'd0, 2'd0);
    send_command(OP_PUT, 8'h43, 6'd0, 2'd0);
    send_command(OP_GOTO, 8'h00, 6'd39, 2'd1);
    send_command(OP_PUT, 8'h44, 6'd0, 2'd0);
    send_command(OP_GOTO, 8'h00, 6'd39, 2'd3);
    send_command(OP_PUT, 8'h45, 6'd0, 2'd0);
    send_command(OP_GOTO, 8'h00, 6'd63, 2'd2);
    send_command(OP_PUT, 8'h46, 6'd0, 2'd0);
  endtask

  task automatic test_row_count_cases();
    write_row_count(3'd1);
    send_command(OP_GOTO, 8'h00, 6'd63, 2'd0);
    send_command(OP_PUT, 8'h30, 6'd0, 2'd0);
    send_command(OP_GOTO, 8'h00, 6'd39, 2'd1);
    send_command(OP_PUT, 8'h31, 6'd0, 2'd0);
    send_command(OP_GOTO, 8'h00, 6'd39, 2'd0);
    send_command(OP_PUT, 8'h32, 6'd0, 2'd0);
    write_row_count(3'd7);
    send_command(OP_GOTO, 8'h00, 6'd39, 2'd3);
    send_command(OP_PUT, 8'h33, 6'd0, 2'd0);
    write_row_count(3'd0);
    send_command(OP_GOTO, 8'h00, 6'd10, 2'd1);
    send_command(OP_PUT, 8'h34, 6'd0, 2'd0);
    write_row_count(3'd4);
    send_command(OP_PUT, 8'h35, 6'd0, 2'd0);
  endtask

  task automatic test_random_traffic();
    logic [2:0] settings[5];
    settings = '{3'd2, 3'd3, 3'd1, 3'd7, 3'd0};
    foreach (settings[s]) begin
      write_row_count(settings[s]);
      repeat (ITEMS_PER_PHASE) send_random_command();
    end
  endtask

  // sink holds off while commands keep coming, then the source waits for the drain
  task automatic test_output_backpressure();
    write_row_count(3'd2);
    hold_off_left = 300;
    repeat (12) send_command(OP_PUT, 8'($urandom_range(0, 255)), 6'd0, 2'd0);
    wait_drained();
    repeat (6) send_random_command();
  endtask

  task automatic test_steady_traffic();
    wait_drained();
    idle_on = 1'b0;
    repeat (40) send_random_command();
  endtask

  initial begin
    rst_n            = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.operation = OP_INIT;
    cmd_if.char_code = 8'd0;
    cmd_if.column    = 6'd0;
    cmd_if.row       = 2'd0;
    cfg_if.valid     = 1'b0;
    cfg_if.row_count = 3'd0;
    cursor_col       = 6'd0;
    cursor_row       = 2'd0;
    row_count_cfg    = 3'd2;
    mismatch_count   = 0;
    cycle_count      = 0;
    hold_off_left    = 0;
    stall_left       = 0;
    idle_on          = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_commands();
    test_line_wrap();
    test_row_count_cases();
    test_random_traffic();
    test_output_backpressure();
    test_steady_traffic();

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("char_lcd_4bit_command_sequencer test passed");
    end else begin
      $display("char_lcd_4bit_command_sequencer test failed");
    end
    $finish;
  end

endmodule
